/* rtl/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Item and result structs, the decoder mode enum, error codes, character
// codes and the small hex and UTF-8 encoding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Default width of the per-string decoded length counter.
  localparam int LENGTH_WIDTH_DEF = 16;
  // Width of the budget register and its value after reset.
  localparam int MAX_W = 16;
  localparam logic [MAX_W-1:0] MAX_RESET = 16'd4096;
  // Depth of the queue between decoder and serializer.
  localparam int QUEUE_DEPTH = 4;

  // Error codes reported on the result channel.
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_CONTROL     = 4'd1;
  localparam logic [3:0] ERR_TRUNC_ESC   = 4'd2;
  localparam logic [3:0] ERR_BAD_ESC     = 4'd3;
  localparam logic [3:0] ERR_BAD_LEAD    = 4'd4;
  localparam logic [3:0] ERR_TRUNC_UTF8  = 4'd5;
  localparam logic [3:0] ERR_BAD_SECOND  = 4'd6;
  localparam logic [3:0] ERR_BAD_CONT    = 4'd7;
  localparam logic [3:0] ERR_TRUNC_HEX   = 4'd8;
  localparam logic [3:0] ERR_BAD_HEX     = 4'd9;
  localparam logic [3:0] ERR_LONE_HIGH   = 4'd10;
  localparam logic [3:0] ERR_BAD_LOW     = 4'd11;
  localparam logic [3:0] ERR_LONE_LOW    = 4'd12;
  localparam logic [3:0] ERR_UNTERM      = 4'd13;
  localparam logic [3:0] ERR_TOO_LONG    = 4'd14;

  // Character codes the decoder reacts to.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Decoder modes.
  typedef enum logic [2:0] {
    M_PLAIN,
    M_ESC,
    M_UTF,
    M_HEX1,
    M_HI_BS,
    M_HI_U,
    M_HEX2
  } mode_t;

  // One input item.
  typedef struct packed {
    logic [7:0] input_byte;
    logic       input_ended;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_done;
    logic [3:0] error_code;
  } result_t;

  // One queued unit: either up to four decoded bytes or one status result.
  typedef struct packed {
    logic            is_stat;
    logic [1:0]      nm1;
    logic [3:0][7:0] bytes;
    logic            done;
    logic [3:0]      err;
  } unit_t;

  // Encoded code point: byte count minus one and the bytes, first in [0].
  typedef struct packed {
    logic [1:0]      nm1;
    logic [3:0][7:0] bytes;
  } enc_t;

  // Hex character to value; bit 4 set marks a non-hex character.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, 4'(c - 8'h37)};
    end
    return d;
  endfunction

  // UTF-8 encoding of a code point up to 21 bits.
  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.nm1 = 2'd0;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.nm1 = 2'd1;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.nm1 = 2'd2;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.nm1 = 2'd3;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/jsu_front.sv */
// ----------------------------------------------------------------------------
// jsu_front: byte classifier and escape / UTF-8 decoder
// Takes one byte per cycle unless the queue is full, tracks the decode mode,
// checks the length budget and queues whole decoded units or status results.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front #(
  parameter int LENGTH_WIDTH = jsu_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire jsu_pkg::in_item_t  in_data,
  input  wire logic               cfg_valid,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output jsu_pkg::unit_t          q_unit
);
  import jsu_pkg::*;

  localparam int CW = ((LENGTH_WIDTH > MAX_W) ? LENGTH_WIDTH : MAX_W) + 1;

  mode_t                   mode_r, mode_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [MAX_W-1:0]        max_r, max_nxt;
  logic [7:0]              lead_r, lead_nxt;
  logic [1:0]              need_r, need_nxt;
  logic [1:0]              got_r, got_nxt;
  logic [2:0][7:0]         buf_r, buf_nxt;
  logic [15:0]             hex_r, hex_nxt;
  logic [1:0]              hcnt_r, hcnt_nxt;
  logic                    hbad_r, hbad_nxt;
  logic [9:0]              high_r, high_nxt;

  logic            fire;
  logic [7:0]      c;
  logic [4:0]      dig;
  logic [15:0]     hex_new;
  logic [20:0]     cp;
  enc_t            enc;
  logic [2:0][7:0] bnow;
  logic [7:0]      lo_lim, hi_lim;
  logic [CW-1:0]   max_ext, cmask, budget, sum;

  logic            emit, fail_v, done_v;
  logic [1:0]      em_nm1;
  logic [3:0][7:0] em_bytes;
  logic [3:0]      fail_code;

  // The queue slot decides whether a byte can be taken.
  assign in_stall = q_full;
  assign fire     = in_valid & ~q_full;
  assign c        = in_data.input_byte;

  // Shared datapath pieces: hex digit, code point encoding, UTF-8 limits.
  always_comb begin
    dig     = hex_digit(c);
    hex_new = {hex_r[11:0], dig[3:0]};
    if (mode_r == M_HEX2) begin
      cp = 21'h10000 + {1'b0, high_r, hex_new[9:0]};
    end else begin
      cp = {5'd0, hex_new};
    end
    enc = encode_cp(cp);
    bnow[0] = (got_r == 2'd0) ? c : buf_r[0];
    bnow[1] = (got_r == 2'd1) ? c : buf_r[1];
    bnow[2] = (got_r == 2'd2) ? c : buf_r[2];
    lo_lim = 8'h80;
    hi_lim = 8'hBF;
    if (lead_r == 8'hE0) lo_lim = 8'hA0;
    if (lead_r == 8'hED) hi_lim = 8'h9F;
    if (lead_r == 8'hF0) lo_lim = 8'h90;
    if (lead_r == 8'hF4) hi_lim = 8'h8F;
  end

  // Effective length budget, limited to what the counter can hold.
  always_comb begin
    max_ext = CW'(max_r);
    cmask   = (CW'(1) << LENGTH_WIDTH) - CW'(1);
    budget  = (max_ext > cmask) ? cmask : max_ext;
    sum     = CW'(len_r) + CW'(em_nm1) + CW'(1);
  end

  // Configuration write; the port never holds off.
  assign max_nxt = cfg_valid ? cfg_data : max_r;

  // Decode mode transitions and unit generation.
  always_comb begin
    mode_nxt  = mode_r;
    len_nxt   = len_r;
    lead_nxt  = lead_r;
    need_nxt  = need_r;
    got_nxt   = got_r;
    buf_nxt   = buf_r;
    hex_nxt   = hex_r;
    hcnt_nxt  = hcnt_r;
    hbad_nxt  = hbad_r;
    high_nxt  = high_r;
    emit      = 1'b0;
    fail_v    = 1'b0;
    done_v    = 1'b0;
    fail_code = ERR_NONE;
    em_nm1    = 2'd0;
    em_bytes  = '0;
    q_push    = 1'b0;
    q_unit    = '0;

    if (fire) begin
      if (in_data.input_ended) begin
        // End of input: the code depends on how far the current unit got.
        fail_v = 1'b1;
        case (mode_r)
          M_ESC:   fail_code = ERR_TRUNC_ESC;
          M_UTF:   fail_code = ERR_TRUNC_UTF8;
          M_HEX1:  fail_code = ERR_TRUNC_HEX;
          M_HI_BS: fail_code = ERR_LONE_HIGH;
          M_HI_U:  fail_code = ERR_LONE_HIGH;
          M_HEX2:  fail_code = ERR_BAD_LOW;
          default: fail_code = ERR_UNTERM;
        endcase
      end else begin
        case (mode_r)
          M_PLAIN: begin
            if (c == CH_QUOTE) begin
              done_v = 1'b1;
            end else if (c < CH_SPACE) begin
              fail_v    = 1'b1;
              fail_code = ERR_CONTROL;
            end else if (c == CH_BSLASH) begin
              mode_nxt = M_ESC;
            end else if (c < 8'h80) begin
              emit        = 1'b1;
              em_bytes[0] = c;
            end else if (c >= 8'hC2 && c <= 8'hDF) begin
              need_nxt = 2'd1;
              lead_nxt = c;
              got_nxt  = 2'd0;
              mode_nxt = M_UTF;
            end else if (c >= 8'hE0 && c <= 8'hEF) begin
              need_nxt = 2'd2;
              lead_nxt = c;
              got_nxt  = 2'd0;
              mode_nxt = M_UTF;
            end else if (c >= 8'hF0 && c <= 8'hF4) begin
              need_nxt = 2'd3;
              lead_nxt = c;
              got_nxt  = 2'd0;
              mode_nxt = M_UTF;
            end else begin
              fail_v    = 1'b1;
              fail_code = ERR_BAD_LEAD;
            end
          end
          M_ESC: begin
            emit = 1'b1;
            case (c)
              CH_QUOTE:  em_bytes[0] = c;
              CH_BSLASH: em_bytes[0] = c;
              CH_SLASH:  em_bytes[0] = c;
              CH_B:      em_bytes[0] = 8'h08;
              CH_F:      em_bytes[0] = 8'h0C;
              CH_N:      em_bytes[0] = 8'h0A;
              CH_R:      em_bytes[0] = 8'h0D;
              CH_T:      em_bytes[0] = 8'h09;
              CH_U: begin
                emit     = 1'b0;
                hex_nxt  = 16'd0;
                hcnt_nxt = 2'd0;
                hbad_nxt = 1'b0;
                mode_nxt = M_HEX1;
              end
              default: begin
                emit      = 1'b0;
                fail_v    = 1'b1;
                fail_code = ERR_BAD_ESC;
              end
            endcase
          end
          M_UTF: begin
            buf_nxt[got_r] = c;
            got_nxt        = got_r + 2'd1;
            if (got_r + 2'd1 == need_r) begin
              // Whole sequence present: judge second byte, then the rest.
              if (bnow[0] < lo_lim || bnow[0] > hi_lim) begin
                fail_v    = 1'b1;
                fail_code = ERR_BAD_SECOND;
              end else if ((need_r >= 2'd2 && (bnow[1] < 8'h80 || bnow[1] > 8'hBF)) ||
                           (need_r == 2'd3 && (bnow[2] < 8'h80 || bnow[2] > 8'hBF))) begin
                fail_v    = 1'b1;
                fail_code = ERR_BAD_CONT;
              end else begin
                emit        = 1'b1;
                em_nm1      = need_r;
                em_bytes[0] = lead_r;
                em_bytes[1] = bnow[0];
                em_bytes[2] = bnow[1];
                em_bytes[3] = bnow[2];
              end
            end
          end
          M_HEX1: begin
            hex_nxt  = hex_new;
            hbad_nxt = hbad_r | dig[4];
            hcnt_nxt = hcnt_r + 2'd1;
            if (hcnt_r == 2'd3) begin
              if (hbad_r | dig[4]) begin
                fail_v    = 1'b1;
                fail_code = ERR_BAD_HEX;
              end else if (hex_new >= 16'hD800 && hex_new <= 16'hDBFF) begin
                high_nxt = hex_new[9:0];
                mode_nxt = M_HI_BS;
              end else if (hex_new >= 16'hDC00 && hex_new <= 16'hDFFF) begin
                fail_v    = 1'b1;
                fail_code = ERR_LONE_LOW;
              end else begin
                emit     = 1'b1;
                em_nm1   = enc.nm1;
                em_bytes = enc.bytes;
              end
            end
          end
          M_HI_BS: begin
            if (c != CH_BSLASH) begin
              fail_v    = 1'b1;
              fail_code = ERR_LONE_HIGH;
            end else begin
              mode_nxt = M_HI_U;
            end
          end
          M_HI_U: begin
            if (c != CH_U) begin
              fail_v    = 1'b1;
              fail_code = ERR_LONE_HIGH;
            end else begin
              hex_nxt  = 16'd0;
              hcnt_nxt = 2'd0;
              mode_nxt = M_HEX2;
            end
          end
          M_HEX2: begin
            if (dig[4]) begin
              fail_v    = 1'b1;
              fail_code = ERR_BAD_LOW;
            end else begin
              hex_nxt  = hex_new;
              hcnt_nxt = hcnt_r + 2'd1;
              if (hcnt_r == 2'd3) begin
                if (hex_new < 16'hDC00 || hex_new > 16'hDFFF) begin
                  fail_v    = 1'b1;
                  fail_code = ERR_BAD_LOW;
                end else begin
                  emit     = 1'b1;
                  em_nm1   = enc.nm1;
                  em_bytes = enc.bytes;
                end
              end
            end
          end
          default: begin
            fail_v    = 1'b1;
            fail_code = ERR_UNTERM;
          end
        endcase
      end

      // A complete unit is counted against the budget before it goes out.
      if (emit) begin
        mode_nxt = M_PLAIN;
        if (sum > budget) begin
          fail_v    = 1'b1;
          fail_code = ERR_TOO_LONG;
        end else begin
          len_nxt      = sum[LENGTH_WIDTH-1:0];
          q_push       = 1'b1;
          q_unit.nm1   = em_nm1;
          q_unit.bytes = em_bytes;
        end
      end

      // Closing quote or error: one status result, then a fresh string.
      if (fail_v || done_v) begin
        q_push         = 1'b1;
        q_unit         = '0;
        q_unit.is_stat = 1'b1;
        q_unit.done    = done_v;
        q_unit.err     = fail_code;
        mode_nxt       = M_PLAIN;
        len_nxt        = '0;
        lead_nxt       = 8'd0;
        need_nxt       = 2'd0;
        got_nxt        = 2'd0;
        buf_nxt        = '0;
        hex_nxt        = 16'd0;
        hcnt_nxt       = 2'd0;
        hbad_nxt       = 1'b0;
        high_nxt       = 10'd0;
      end
    end
  end

  // Decoder state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      len_r  <= '0;
      max_r  <= MAX_RESET;
      lead_r <= 8'd0;
      need_r <= 2'd0;
      got_r  <= 2'd0;
      buf_r  <= '0;
      hex_r  <= 16'd0;
      hcnt_r <= 2'd0;
      hbad_r <= 1'b0;
      high_r <= 10'd0;
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      max_r  <= max_nxt;
      lead_r <= lead_nxt;
      need_r <= need_nxt;
      got_r  <= got_nxt;
      buf_r  <= buf_nxt;
      hex_r  <= hex_nxt;
      hcnt_r <= hcnt_nxt;
      hbad_r <= hbad_nxt;
      high_r <= high_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A status result always leaves the decoder at the start of a new string.
  a_stat_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_unit.is_stat |=> mode_r == M_PLAIN && len_r == '0)
    else $error("decoder state not cleared after status result");

  // A decoded unit only goes out when it fits the length budget.
  a_len_budget: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_unit.is_stat |-> sum <= budget)
    else $error("decoded unit exceeds length budget");
`endif

endmodule

`default_nettype wire

/* rtl/jsu_queue.sv */
// ----------------------------------------------------------------------------
// jsu_queue: short unit queue between decoder and serializer
// Holds decoded units so that the decoder and the output side stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire jsu_pkg::unit_t  push_unit,
  output logic                 full,
  input  wire logic            pop,
  output logic                 empty,
  output jsu_pkg::unit_t       head
);
  import jsu_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  unit_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  assign full  = (count_r == (PW + 1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW + 1)'(push) - (PW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_unit;
    end
  end

`ifndef NO_ASSERTIONS
  // The decoder only writes into a free slot.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("unit queue overflow");

  // The serializer only takes from a filled slot.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("unit queue underflow");
`endif

endmodule

`default_nettype wire

/* rtl/jsu_back.sv */
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Splits each queued unit into one result per byte, or one status result,
// and holds the current result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire jsu_pkg::unit_t  q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output jsu_pkg::result_t     out_data
);
  import jsu_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic       valid_r, valid_nxt;
  result_t    res_r, res_nxt;
  logic       load, last;

  // Load a new result when the output register is free or being taken.
  always_comb begin
    load    = !q_empty && (!valid_r || !out_stall);
    last    = q_head.is_stat || (pos_r == q_head.nm1);
    q_pop   = load && last;
    pos_nxt = pos_r;
    if (load) begin
      pos_nxt = last ? 2'd0 : pos_r + 2'd1;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
    res_nxt = res_r;
    if (load) begin
      res_nxt.last_of_run = last;
      if (q_head.is_stat) begin
        res_nxt.data_byte   = 8'd0;
        res_nxt.byte_valid  = 1'b0;
        res_nxt.string_done = q_head.done;
        res_nxt.error_code  = q_head.err;
      end else begin
        res_nxt.data_byte   = q_head.bytes[pos_r];
        res_nxt.byte_valid  = 1'b1;
        res_nxt.string_done = 1'b0;
        res_nxt.error_code  = ERR_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = res_r;

`ifndef NO_ASSERTIONS
  // A data result never also carries a status.
  a_data_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.byte_valid &&
                    (out_data.string_done || out_data.error_code != ERR_NONE)))
    else $error("data result carries a status");
`endif

endmodule

`default_nettype wire

/* rtl/json_string_unescape_utf8_check.sv */
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_check: JSON string body decoder, top level
// Decodes escapes and \u sequences to UTF-8, validates raw UTF-8, enforces
// a decoded length budget and reports the end of each string.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  in_item_t (input_byte, input_ended)
//   out_     output     out_valid/out_stall result_t (byte, flags, error code)
//   cfg_     input      cfg_valid/cfg_ready string byte budget, 16 bits
//
// One input byte is taken every cycle while the unit queue has room.
// Each queued unit gives one to four results, one per cycle while out_stall
// is low; the output register serializes them, so bursts drain at one per cycle.
// Input stalls only when the four-entry unit queue is full.
// Reset is synchronous and active low; it restores the budget to 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_check #(
  parameter int LENGTH_WIDTH = jsu_pkg::LENGTH_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire jsu_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output jsu_pkg::result_t        out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  import jsu_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  unit_t q_unit, q_head;

  // The budget register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  jsu_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_unit   (q_unit)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_unit(q_unit),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
